// ===== hw/rtl/plk_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional list store package
// Shared widths, codes and types for the list store and its cells.
// ----------------------------------------------------------------------------
package plk_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int ACT_W   = 2;
    localparam int POS_W   = 8;
    localparam int VALUE_W = 32;
    localparam int DOUT_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_READ   = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic ins;
        logic rem;
    } t_cell_cmd;

endpackage

// ===== hw/rtl/plk_cell.sv =====
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry and shifts toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module plk_cell #(
    parameter int DATA_WIDTH = plk_pkg::DATA_WIDTH_DEF,
    parameter int IDX_W      = 6,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  plk_pkg::t_cell_cmd    i_cmd,
    input  logic [IDX_W-1:0]      i_at,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_read
);
    import plk_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (MY_IDX > i_at) begin
                r_data <= i_left;
            end else if (MY_IDX == i_at) begin
                r_data <= i_value;
            end
        end else if (i_cmd.rem) begin
            if (MY_IDX >= i_at) begin
                r_data <= i_right;
            end
        end
    end

    assign o_data = r_data;
    assign o_read = (MY_IDX == i_at) ? r_data : '0;

endmodule

// ===== hw/rtl/positional_list_store_top.sv =====
// Each request is registered in the command register; when the output is free, the
// cell row executes it and the result is registered into the output. No new request
// is taken until the current one is executed, and the whole row shifts at once.
// A stalled result holds the row until the result can be loaded into the output.
// Reset clears the entry count, the control state and the output valid.
// Entry contents are not reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
// Positional list store
// Ordered list with insert, remove and read at a position, kept in a cell row.
// ----------------------------------------------------------------------------
module positional_list_store_top #(
    parameter int CAPACITY   = plk_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = plk_pkg::DATA_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [plk_pkg::ACT_W-1:0]   i_action,
    input  logic [plk_pkg::POS_W-1:0]   i_position,
    input  logic [plk_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [plk_pkg::DOUT_W-1:0]  o_data_out,
    output logic [plk_pkg::STAT_W-1:0]  o_status,
    output logic [plk_pkg::COUNT_W-1:0] o_count_out
);
    import plk_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int AW    = (CW > POS_W) ? CW : POS_W;

    t_state                r_state;
    t_state                n_state;
    logic [ACT_W-1:0]      r_action;
    logic [POS_W-1:0]      r_pos;
    logic [VALUE_W-1:0]    r_value;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [DOUT_W-1:0]     r_data_out;
    logic [STAT_W-1:0]     r_status;
    logic [COUNT_W-1:0]    r_count_out;

    logic                  w_accept;
    logic                  w_fire;
    t_status               w_status;
    logic                  w_take;
    logic                  w_ins;
    logic                  w_rem;
    logic [AW-1:0]         w_pos;
    logic [AW-1:0]         w_cnt;
    logic [AW-1:0]         w_at;
    logic [IDX_W-1:0]      w_at_idx;
    t_cell_cmd             w_cmd;
    logic [DATA_WIDTH-1:0] w_cell_value;
    logic [DATA_WIDTH-1:0] w_rd;
    logic [DATA_WIDTH-1:0] w_cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_cell_rd   [CAPACITY];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        w_fire  = 1'b0;
        case (r_state)
            S_IDLE: o_stall = 1'b0;
            S_EXEC: w_fire  = !r_out_valid || !i_stall;
            default: begin
                o_stall = 1'b1;
                w_fire  = 1'b0;
            end
        endcase
    end

    assign w_accept = i_valid && !o_stall;

    always_comb begin
        w_pos    = AW'(r_pos);
        w_cnt    = AW'(r_count);
        w_status = ST_OK;
        w_at     = '0;
        w_take   = 1'b0;
        w_ins    = 1'b0;
        w_rem    = 1'b0;
        n_count  = r_count;
        case (r_action)
            ACT_INSERT: begin
                if (r_count == CW'(CAPACITY)) begin
                    w_status = ST_FULL;
                end else begin
                    w_at    = (w_pos < w_cnt) ? w_pos : w_cnt;
                    w_ins   = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_at    = (w_pos >= w_cnt - 1'b1) ? (w_cnt - 1'b1) : w_pos;
                    w_rem   = 1'b1;
                    w_take  = 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            ACT_READ: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_pos >= w_cnt) begin
                    w_status = ST_RANGE;
                end else begin
                    w_at   = w_pos;
                    w_take = 1'b1;
                end
            end
            default: w_status = ST_RANGE;
        endcase
    end

    assign w_at_idx     = w_at[IDX_W-1:0];
    assign w_cmd.ins    = w_fire && w_ins;
    assign w_cmd.rem    = w_fire && w_rem;
    assign w_cell_value = DATA_WIDTH'(r_value);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_l
            assign w_left = w_cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_inner_r
            assign w_right = w_cell_data[g+1];
        end
        plk_cell #(
            .DATA_WIDTH(DATA_WIDTH),
            .IDX_W     (IDX_W),
            .IDX       (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd),
            .i_at   (w_at_idx),
            .i_value(w_cell_value),
            .i_left (w_left),
            .i_right(w_right),
            .o_data (w_cell_data[g]),
            .o_read (w_cell_rd[g])
        );
    end

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd = w_rd | w_cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_pos    <= i_position;
            r_value  <= i_value;
        end
        if (w_fire) begin
            r_data_out  <= w_take ? DOUT_W'(w_rd) : '0;
            r_status    <= w_status;
            r_count_out <= COUNT_W'(n_count);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data_out  = r_data_out;
    assign o_status    = r_status;
    assign o_count_out = r_count_out;

endmodule

// ===== hw/rtl/plk_checker.sv =====
// ----------------------------------------------------------------------------
// List store checker
// Port-level checks on the requests and results of the positional list store.
// ----------------------------------------------------------------------------
module plk_checker #(
    parameter int CAPACITY = plk_pkg::CAPACITY_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic [plk_pkg::ACT_W-1:0]   i_action,
    input logic [plk_pkg::POS_W-1:0]   i_position,
    input logic [plk_pkg::VALUE_W-1:0] i_value,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [plk_pkg::DOUT_W-1:0]  o_data_out,
    input logic [plk_pkg::STAT_W-1:0]  o_status,
    input logic [plk_pkg::COUNT_W-1:0] o_count_out
);
    import plk_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_action) && $stable(i_position)
            && $stable(i_value))
        else $error("Stalled request transfer changed.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_out) && $stable(o_status)
            && $stable(o_count_out))
        else $error("Stalled result transfer changed.");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_data_out == '0))
        else $error("Failed operation returned nonzero data.");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_count_out == COUNT_W'(CAPACITY)))
        else $error("Full status with a count below capacity.");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_count_out == '0))
        else $error("Empty status with a nonzero count.");

endmodule

bind positional_list_store_top plk_checker #(.CAPACITY(CAPACITY)) u_plk_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list store testbench
// Drives insert, remove, read and unused-code requests through the input
// channel, predicts each result from a local copy of the list and compares
// every output transfer field by field, under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
    import plk_pkg::*;

    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int RANDOM_REQS  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 5_000_000;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } t_list_req;

    typedef struct packed {
        logic [DOUT_W-1:0]  data;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_list_result;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_valid    = 1'b0;
    logic               o_stall;
    logic [ACT_W-1:0]   i_action   = '0;
    logic [POS_W-1:0]   i_position = '0;
    logic [VALUE_W-1:0] i_value    = '0;
    logic               o_valid;
    logic               i_stall    = 1'b0;
    logic [DOUT_W-1:0]  o_data_out;
    logic [STAT_W-1:0]  o_status;
    logic [COUNT_W-1:0] o_count_out;

    t_list_req    pending_reqs[$];
    t_list_result expected_results[$];

    logic [DOUT_W-1:0] list_words [LIST_CAP];
    int list_len        = 0;
    int peak_len        = 0;
    int gen_len         = 0;
    int total_reqs      = 0;
    int req_accepted    = 0;
    int results_checked = 0;
    int fail_count      = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    bit req_done        = 1'b0;
    int burst_left      = 1;
    int gap_left        = 0;
    int stall_tick      = 0;
    t_stall_mode stall_mode = STALL_NONE;

    positional_list_store_top #(
        .CAPACITY   (LIST_CAP),
        .DATA_WIDTH (DATA_WIDTH_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count_out (o_count_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_list_result predict_list_op(t_list_req req);
        t_list_result res;
        int at;
        res.data   = '0;
        res.status = ST_OK;
        case (req.action)
            ACT_INSERT: begin
                if (list_len >= LIST_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    at = (req.position < list_len) ? req.position : list_len;
                    for (int i = list_len; i > at; i--)
                        list_words[i] = list_words[i-1];
                    list_words[at] = req.value;
                    list_len++;
                end
            end
            ACT_REMOVE: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    at = (req.position >= list_len - 1) ? list_len - 1 : req.position;
                    res.data = list_words[at];
                    for (int i = at; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            ACT_READ: begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else if (req.position >= list_len)
                    res.status = ST_RANGE;
                else
                    res.data = list_words[req.position];
            end
            default: begin
                res.status = ST_RANGE;
            end
        endcase
        res.count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    task automatic queue_req(input logic [ACT_W-1:0] action,
                             input logic [POS_W-1:0] pos,
                             input logic [VALUE_W-1:0] value);
        t_list_req req;
        req.action   = action;
        req.position = pos;
        req.value    = value;
        pending_reqs.push_back(req);
        total_reqs++;
        if (action == ACT_INSERT && gen_len < LIST_CAP)
            gen_len++;
        else if (action == ACT_REMOVE && gen_len > 0)
            gen_len--;
    endtask

    // The sender holds a stalled transfer and otherwise moves on in bursts.
    always @(negedge i_clk) begin
        t_list_req next_req;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_done) begin
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                i_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end else begin
                next_req = pending_reqs.pop_front();
                i_valid    <= 1'b1;
                i_action   <= next_req.action;
                i_position <= next_req.position;
                i_value    <= next_req.value;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        stall_tick++;
        if (stall_tick % 64 == 0)
            stall_mode = t_stall_mode'($urandom_range(0, 3));
        case (stall_mode)
            STALL_NONE:     i_stall <= 1'b0;
            STALL_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_stall <= ($urandom_range(0, 9) < 6);
            default:        i_stall <= (stall_tick[2:0] < 3'd3);
        endcase
    end

    always @(posedge i_clk) begin
        t_list_req    seen_req;
        t_list_result want;
        if (!i_rst_n) begin
            req_done <= 1'b0;
        end else begin
            req_done <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                seen_req.action   = i_action;
                seen_req.position = i_position;
                seen_req.value    = i_value;
                expected_results.push_back(predict_list_op(seen_req));
                req_accepted++;
                if (list_len > peak_len)
                    peak_len = list_len;
            end
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, data %0h status %0d count %0d",
                             $time, o_data_out, o_status, o_count_out);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_data_out !== want.data) begin
                        $display("%0t: data_out mismatch, expected %0h, actual %0h",
                                 $time, want.data, o_data_out);
                        fail_count++;
                    end
                    if (o_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, o_status);
                        fail_count++;
                    end
                    if (o_count_out !== want.count) begin
                        $display("%0t: count_out mismatch, expected %0d, actual %0d",
                                 $time, want.count, o_count_out);
                        fail_count++;
                    end
                    results_checked++;
                    status_seen[want.status]++;
                end
            end
        end
    end

    initial begin
        logic [ACT_W-1:0]   action;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
        int roll;
        bit filling;

        queue_req(ACT_READ,   8'd0,   32'h0);
        queue_req(ACT_REMOVE, 8'd0,   32'h0);
        queue_req(ACT_READ,   8'd255, 32'hFFFF_FFFF);
        queue_req(ACT_UNUSED, 8'd0,   32'hFFFF_FFFF);
        queue_req(ACT_INSERT, 8'd0,   32'h0000_0000);
        queue_req(ACT_INSERT, 8'd255, 32'hFFFF_FFFF);
        queue_req(ACT_INSERT, 8'd1,   32'hA5A5_A5A5);
        queue_req(ACT_INSERT, 8'd0,   32'h5A5A_5A5A);
        queue_req(ACT_READ,   8'd0,   32'h0);
        queue_req(ACT_READ,   8'd3,   32'h0);
        queue_req(ACT_READ,   8'd4,   32'h0);
        queue_req(ACT_READ,   8'd255, 32'h0);
        queue_req(ACT_INSERT, 8'd4,   32'h1234_5678);
        queue_req(ACT_REMOVE, 8'd2,   32'hFFFF_FFFF);
        queue_req(ACT_REMOVE, 8'd255, 32'h0);
        queue_req(ACT_REMOVE, 8'd2,   32'h0);
        queue_req(ACT_REMOVE, 8'd0,   32'h0);
        queue_req(ACT_READ,   8'd0,   32'h0);
        queue_req(ACT_REMOVE, 8'd128, 32'h0);
        queue_req(ACT_REMOVE, 8'd0,   32'h0);
        queue_req(ACT_UNUSED, 8'd255, 32'h0);

        // The random part alternates between filling the list up to its
        // capacity and draining it, so that full and empty are both reached.
        filling = 1'b1;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (filling && gen_len == LIST_CAP && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (!filling && gen_len == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                filling = !filling;
            roll = $urandom_range(0, 99);
            if (roll < 60)
                action = filling ? ACT_INSERT : ACT_REMOVE;
            else if (roll < 75)
                action = filling ? ACT_REMOVE : ACT_INSERT;
            else if (roll < 95)
                action = ACT_READ;
            else
                action = ACT_UNUSED;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: pos = POS_W'($urandom_range(0, gen_len));
                6:                pos = POS_W'(gen_len);
                7:                pos = (gen_len > 0) ? POS_W'(gen_len - 1) : '0;
                default:          pos = POS_W'($urandom_range(0, 255));
            endcase
            roll = $urandom_range(0, 9);
            if (roll == 0)
                value = '0;
            else if (roll == 1)
                value = '1;
            else
                value = $urandom();
            queue_req(action, pos, value);
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        while (req_accepted < total_reqs)
            @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results from %0d request transfers; the list peaked at %0d of %0d.",
                 results_checked, req_accepted, peak_len, LIST_CAP);
        $display("Statuses seen: ok %0d, empty %0d, out of range %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_RANGE], status_seen[ST_FULL]);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d results still expected.", expected_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
